>>> rtl/mrfc_pkg.sv
// shared types, constants and crc function for the modbus response frame checker
package mrfc_pkg;

   localparam int unsigned MAX_WORDS  = 1024;
   localparam int unsigned BYTE_SHIFT = 1;

   // word and byte counters saturate here
   localparam logic [10:0] COUNT_CAP =
      (MAX_WORDS < 2047) ? 11'(MAX_WORDS) : 11'd2047;

   localparam logic [10:0] STAMP_WORDS = 11'd4;

   // top nibble of a response word
   localparam logic [3:0] OP_READ  = 4'h9;
   localparam logic [3:0] OP_END   = 4'hA;
   localparam logic [3:0] OP_STAMP = 4'hB;

   localparam logic [15:0] END_WORD  = 16'hA000;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;

   localparam logic [3:0] STAMP_FULL = 4'd8;
   localparam logic [3:0] STAMP_SAT  = 4'd15;
   localparam logic [1:0] ENDS_SAT   = 2'd3;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_FEW_BYTES = 3'd2;
   localparam logic [2:0] ST_END_COUNT = 3'd3;
   localparam logic [2:0] ST_NO_STAMP  = 3'd4;
   localparam logic [2:0] ST_LAST_END  = 3'd5;
   localparam logic [2:0] ST_CRC       = 3'd6;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [15:0] word;
      logic        final_word;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [2:0]  status;
      logic [63:0] begin_stamp;
      logic [63:0] end_stamp;
      logic [10:0] payload_count;
      logic [15:0] crc_received;
      logic [15:0] crc_computed;
      logic        last;
   } rsp_type;

   // results an accepted item pushes, in order first then second
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/mrfc_front.sv
// front part: classifies response words, keeps frame state and builds results
module mrfc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_accept,
   input  mrfc_pkg::req_type  req_data,
   output mrfc_pkg::push_type push,
   output mrfc_pkg::rsp_type  entry0,
   output mrfc_pkg::rsp_type  entry1
);

   logic [10:0] pos_ff,   pos_in;
   logic [63:0] begin_ff, begin_in;
   logic [63:0] end_ff,   end_in;
   logic [3:0]  stamp_ff, stamp_in;
   logic [1:0]  ends_ff,  ends_in;
   logic [10:0] total_ff, total_in;
   logic [7:0]  hold0_ff, hold0_in;
   logic [7:0]  hold1_ff, hold1_in;
   logic [15:0] crc_ff,   crc_in;

   logic [3:0]        op;
   logic [15:0]       shifted;
   logic              release_byte;
   logic              is_end;
   logic [15:0]       rx;
   logic [2:0]        status;
   mrfc_pkg::rsp_type data_rsp;
   mrfc_pkg::rsp_type sum_rsp;

   always_comb begin
      pos_in       = pos_ff;
      begin_in     = begin_ff;
      end_in       = end_ff;
      stamp_in     = stamp_ff;
      ends_in      = ends_ff;
      total_in     = total_ff;
      hold0_in     = hold0_ff;
      hold1_in     = hold1_ff;
      crc_in       = crc_ff;
      op           = req_data.word[15:12];
      shifted      = req_data.word >> mrfc_pkg::BYTE_SHIFT;
      release_byte = 1'b0;
      is_end       = (req_data.word == mrfc_pkg::END_WORD);

      if (pos_ff < mrfc_pkg::COUNT_CAP) begin
         if (pos_ff < mrfc_pkg::STAMP_WORDS) begin
            begin_in = begin_ff | ({48'h0, req_data.word} << {pos_ff[1:0], 4'b0000});
         end else begin
            if (op == mrfc_pkg::OP_READ) begin
               if (total_ff >= 11'd2) begin
                  release_byte = 1'b1;
                  crc_in       = mrfc_pkg::crc_byte(crc_ff, hold0_ff);
               end
               hold0_in = hold1_ff;
               hold1_in = shifted[7:0];
               if (total_ff < mrfc_pkg::COUNT_CAP) begin
                  total_in = total_ff + 11'd1;
               end
            end else if (op == mrfc_pkg::OP_STAMP) begin
               if (stamp_ff < mrfc_pkg::STAMP_FULL) begin
                  end_in = end_ff | ({56'h0, req_data.word[7:0]} << {stamp_ff[2:0], 3'b000});
               end
               if (stamp_ff < mrfc_pkg::STAMP_SAT) begin
                  stamp_in = stamp_ff + 4'd1;
               end
            end else if (op == mrfc_pkg::OP_END) begin
               if (ends_ff < mrfc_pkg::ENDS_SAT) begin
                  ends_in = ends_ff + 2'd1;
               end
            end
         end
         pos_in = pos_ff + 11'd1;
      end

      // summary checks on the state after this word, first failure wins
      rx = {hold1_in, hold0_in};
      if (pos_in <= mrfc_pkg::STAMP_WORDS) begin
         status = mrfc_pkg::ST_SHORT;
      end else if (total_in < 11'd3) begin
         status = mrfc_pkg::ST_FEW_BYTES;
      end else if (ends_in != 2'd1) begin
         status = mrfc_pkg::ST_END_COUNT;
      end else if (stamp_in != mrfc_pkg::STAMP_FULL) begin
         status = mrfc_pkg::ST_NO_STAMP;
      end else if (!is_end) begin
         status = mrfc_pkg::ST_LAST_END;
      end else if (rx != crc_in) begin
         status = mrfc_pkg::ST_CRC;
      end else begin
         status = mrfc_pkg::ST_OK;
      end

      data_rsp           = '0;
      data_rsp.kind      = mrfc_pkg::KIND_DATA;
      data_rsp.data_byte = hold0_ff;
      data_rsp.last      = !req_data.final_word;

      sum_rsp               = '0;
      sum_rsp.kind          = mrfc_pkg::KIND_SUMMARY;
      sum_rsp.status        = status;
      sum_rsp.begin_stamp   = begin_in;
      sum_rsp.end_stamp     = end_in;
      sum_rsp.payload_count = total_in;
      sum_rsp.crc_received  = rx;
      sum_rsp.crc_computed  = crc_in;
      sum_rsp.last          = 1'b1;

      // frame done: back to the reset state for the next one
      if (req_data.final_word) begin
         pos_in   = '0;
         begin_in = '0;
         end_in   = '0;
         stamp_in = '0;
         ends_in  = '0;
         total_in = '0;
         hold0_in = '0;
         hold1_in = '0;
         crc_in   = mrfc_pkg::CRC_INIT;
      end
   end

   always_comb begin
      push.first  = req_accept && (release_byte || req_data.final_word);
      push.second = req_accept && release_byte && req_data.final_word;
      entry0      = release_byte ? data_rsp : sum_rsp;
      entry1      = sum_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         begin_ff <= '0;
         end_ff   <= '0;
         stamp_ff <= '0;
         ends_ff  <= '0;
         total_ff <= '0;
         hold0_ff <= '0;
         hold1_ff <= '0;
         crc_ff   <= mrfc_pkg::CRC_INIT;
      end else if (req_accept) begin
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         end_ff   <= end_in;
         stamp_ff <= stamp_in;
         ends_ff  <= ends_in;
         total_ff <= total_in;
         hold0_ff <= hold0_in;
         hold1_ff <= hold1_in;
         crc_ff   <= crc_in;
      end
   end

endmodule

>>> rtl/mrfc_queue.sv
// back part: result queue taking up to two items a cycle and driving the result channel
module mrfc_queue (
   input  logic               clock,
   input  logic               reset,
   input  mrfc_pkg::push_type push,
   input  mrfc_pkg::rsp_type  entry0,
   input  mrfc_pkg::rsp_type  entry1,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mrfc_pkg::rsp_type  rsp_data
);

   mrfc_pkg::rsp_type               mem_ff [mrfc_pkg::QUEUE_DEPTH];
   logic [mrfc_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mrfc_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mrfc_pkg::QCNT_W-1:0]     count_ff,  count_in;
   logic                            pop;
   logic [mrfc_pkg::QPTR_W-1:0]     wr_next;

   always_comb begin
      rsp_valid = (count_ff != '0);
      rsp_data  = mem_ff[rd_ptr_ff];
      pop       = rsp_valid && !rsp_stall;
      // space for two results, decided from registered state only
      room      = (count_ff <= mrfc_pkg::QCNT_W'(mrfc_pkg::QUEUE_DEPTH - 2));
      wr_next   = wr_ptr_ff + mrfc_pkg::QPTR_W'(1);
      wr_ptr_in = wr_ptr_ff + mrfc_pkg::QPTR_W'(push.first) + mrfc_pkg::QPTR_W'(push.second);
      rd_ptr_in = rd_ptr_ff + mrfc_pkg::QPTR_W'(pop);
      count_in  = count_ff + mrfc_pkg::QCNT_W'(push.first) + mrfc_pkg::QCNT_W'(push.second)
                  - mrfc_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         mem_ff[wr_ptr_ff] <= entry0;
      end
      if (push.second) begin
         mem_ff[wr_next] <= entry1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/modbus_response_frame_checker.sv
// top level of the modbus rtu response frame checker
// Request channel: one 16-bit response fifo word per item plus a final_word
// mark. The first four words of a frame build the begin timestamp; later
// words are read bytes, timestamp bytes or end-frame marks by top nibble.
// Result channel: released payload bytes (kind 0) and, on the final word,
// one frame summary (kind 1) with status, timestamps, byte count and crc.
// An item yields zero, one or two results; last marks its final result.
// A result is offered the cycle after its item is accepted when the queue
// is empty. Throughput: one item per cycle while the queue has room for two
// results and each item makes at most one result. The result queue (four
// entries) has a single output, so items making two results build up in it.
// req_stall is high while the queue has room for fewer than two results.
// A stalled result holds on rsp_data; the front keeps accepting until
// req_stall rises. Reset clears the frame state (crc to 0xffff) and empties
// the queue; the block takes items the first cycle after reset.
module modbus_response_frame_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mrfc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mrfc_pkg::rsp_type rsp_data
);

   logic               room;
   logic               req_accept;
   mrfc_pkg::push_type push;
   mrfc_pkg::rsp_type  entry0;
   mrfc_pkg::rsp_type  entry1;

   always_comb begin
      req_stall  = !room;
      req_accept = req_valid && room;
   end

   mrfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .push       (push),
      .entry0     (entry0),
      .entry1     (entry1)
   );

   mrfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry0    (entry0),
      .entry1    (entry1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> verif/modbus_response_frame_checker_tb.sv
// self-checking testbench for the modbus response frame checker
module modbus_response_frame_checker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_WORDS = 1850;
   localparam int unsigned IDLE_LIMIT   = 3000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned HOLD_AFTER   = 400;

   typedef enum int unsigned {
      FR_GOOD,
      FR_BAD_CRC,
      FR_EXTRA_STAMP,
      FR_FEW_STAMP,
      FR_MULTI_END,
      FR_LAST_NOT_END,
      FR_FEW_BYTES,
      FR_SHORT,
      FR_NOISE,
      FR_LONG
   } frame_flavor_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mrfc_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b1;
   mrfc_pkg::rsp_type rsp_data;

   modbus_response_frame_checker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mrfc_pkg::req_type words_to_send[$];
   mrfc_pkg::rsp_type pending_results[$];
   int unsigned items_queued  = 0;
   int unsigned words_taken   = 0;
   int unsigned error_count   = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned send_gap      = 0;
   int unsigned stall_left    = 0;
   int unsigned hold_left     = 0;
   bit          pressure_done = 1'b0;
   bit          calm          = 1'b0;

   // frame state of the predictor
   logic [10:0] frame_pos   = '0;
   logic [63:0] begin_acc   = '0;
   logic [63:0] end_acc     = '0;
   logic [3:0]  stamp_cnt   = '0;
   logic [1:0]  end_cnt     = '0;
   logic [10:0] byte_cnt    = '0;
   logic [7:0]  hold_lo     = '0;
   logic [7:0]  hold_hi     = '0;
   logic [15:0] crc_run     = 16'hFFFF;
   logic        saw_end     = 1'b0;

   function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      r = crc ^ 16'(b);
      repeat (8) r = r[0] ? ((r >> 1) ^ mrfc_pkg::CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic logic [15:0] read_word(logic [7:0] b);
      logic [15:0] w;
      w = {mrfc_pkg::OP_READ, 12'($urandom)};
      w[mrfc_pkg::BYTE_SHIFT +: 8] = b;
      return w;
   endfunction

   function automatic logic [15:0] stamp_word(logic [7:0] b);
      return {mrfc_pkg::OP_STAMP, 4'($urandom), b};
   endfunction

   // a word whose top nibble the block ignores
   function automatic logic [15:0] noise_word();
      logic [15:0] w;
      w = 16'($urandom);
      while (w[15:12] == mrfc_pkg::OP_READ || w[15:12] == mrfc_pkg::OP_END ||
             w[15:12] == mrfc_pkg::OP_STAMP)
         w = 16'($urandom);
      return w;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic push_word(input logic [15:0] w, input logic fin);
      mrfc_pkg::req_type item;
      item.word       = w;
      item.final_word = fin;
      words_to_send.insert(words_to_send.size(), item);
      items_queued++;
   endtask

   task automatic model_frame_word(input mrfc_pkg::req_type item);
      mrfc_pkg::rsp_type fresh[$];
      mrfc_pkg::rsp_type r;
      logic [7:0]        b;
      logic [15:0]       rx;
      logic [2:0]        st;
      if (frame_pos < mrfc_pkg::COUNT_CAP) begin
         if (frame_pos < mrfc_pkg::STAMP_WORDS) begin
            begin_acc |= 64'(item.word) << (16 * frame_pos);
         end else begin
            case (item.word[15:12])
               mrfc_pkg::OP_READ: begin
                  b = 8'(item.word >> mrfc_pkg::BYTE_SHIFT);
                  if (byte_cnt >= 2) begin
                     r           = '0;
                     r.kind      = mrfc_pkg::KIND_DATA;
                     r.data_byte = hold_lo;
                     crc_run     = crc_step(crc_run, hold_lo);
                     fresh.insert(fresh.size(), r);
                  end
                  hold_lo = hold_hi;
                  hold_hi = b;
                  if (byte_cnt < mrfc_pkg::COUNT_CAP) byte_cnt++;
               end
               mrfc_pkg::OP_STAMP: begin
                  if (stamp_cnt < mrfc_pkg::STAMP_FULL)
                     end_acc[8 * stamp_cnt +: 8] = item.word[7:0];
                  if (stamp_cnt < mrfc_pkg::STAMP_SAT) stamp_cnt++;
               end
               mrfc_pkg::OP_END: begin
                  if (end_cnt < mrfc_pkg::ENDS_SAT) end_cnt++;
               end
               default: ;
            endcase
         end
         frame_pos++;
      end
      saw_end = (item.word == mrfc_pkg::END_WORD);

      if (item.final_word) begin
         rx = {hold_hi, hold_lo};
         if (frame_pos <= mrfc_pkg::STAMP_WORDS) st = mrfc_pkg::ST_SHORT;
         else if (byte_cnt < 3) st = mrfc_pkg::ST_FEW_BYTES;
         else if (end_cnt != 2'd1) st = mrfc_pkg::ST_END_COUNT;
         else if (stamp_cnt != mrfc_pkg::STAMP_FULL) st = mrfc_pkg::ST_NO_STAMP;
         else if (!saw_end) st = mrfc_pkg::ST_LAST_END;
         else if (rx != crc_run) st = mrfc_pkg::ST_CRC;
         else st = mrfc_pkg::ST_OK;
         r               = '0;
         r.kind          = mrfc_pkg::KIND_SUMMARY;
         r.status        = st;
         r.begin_stamp   = begin_acc;
         r.end_stamp     = end_acc;
         r.payload_count = byte_cnt;
         r.crc_received  = rx;
         r.crc_computed  = crc_run;
         fresh.insert(fresh.size(), r);
         // the block starts the next frame from its reset state
         frame_pos = '0;
         begin_acc = '0;
         end_acc   = '0;
         stamp_cnt = '0;
         end_cnt   = '0;
         byte_cnt  = '0;
         hold_lo   = '0;
         hold_hi   = '0;
         crc_run   = 16'hFFFF;
         saw_end   = 1'b0;
      end

      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) pending_results.insert(pending_results.size(), fresh[i]);
   endtask

   task automatic queue_frame(input frame_flavor_type flavor);
      logic [7:0]  bytes[$];
      logic [15:0] crc;
      logic [15:0] last_word;
      int unsigned n, n_stamp, n_ends, ri, si, ei, r, idx;
      if (flavor == FR_SHORT || flavor == FR_NOISE) begin
         n = (flavor == FR_SHORT) ? $urandom_range(1, 4) : $urandom_range(5, 16);
         for (int i = 0; i < n; i++) push_word(16'($urandom), i == n - 1);
         return;
      end
      for (int i = 0; i < 4; i++) push_word(16'($urandom), 1'b0);

      if (flavor == FR_LONG) n = 1030;
      else if (flavor == FR_FEW_BYTES) n = $urandom_range(0, 2);
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(13, 48);
      else n = $urandom_range(1, 12);
      crc = 16'hFFFF;
      for (int i = 0; i < n; i++) begin
         bytes.insert(bytes.size(), 8'($urandom));
         crc = crc_step(crc, bytes[i]);
      end
      if (flavor != FR_FEW_BYTES) begin
         bytes.insert(bytes.size(), crc[7:0]);
         bytes.insert(bytes.size(), crc[15:8]);
      end
      if (flavor == FR_BAD_CRC) begin
         idx = $urandom_range(0, bytes.size() - 1);
         bytes[idx][$urandom_range(0, 7)] ^= 1'b1;
      end

      if (flavor == FR_EXTRA_STAMP) n_stamp = $urandom_range(9, 17);
      else if (flavor == FR_FEW_STAMP) n_stamp = $urandom_range(0, 7);
      else n_stamp = 8;
      n_ends = (flavor == FR_MULTI_END) ? $urandom_range(1, 3) : 0;

      // read bytes and stamp bytes keep their own order but interleave freely
      ri = 0;
      si = 0;
      ei = 0;
      while (ri < bytes.size() || si < n_stamp || ei < n_ends) begin
         r = $urandom_range(0, 19);
         if (r == 0) begin
            push_word(noise_word(), 1'b0);
         end else if (r <= 2 && ei < n_ends) begin
            push_word(mrfc_pkg::END_WORD, 1'b0);
            ei++;
         end else if (r <= 8 && si < n_stamp) begin
            push_word(stamp_word(8'($urandom)), 1'b0);
            si++;
         end else if (ri < bytes.size()) begin
            push_word(read_word(bytes[ri]), 1'b0);
            ri++;
         end else if (si < n_stamp) begin
            push_word(stamp_word(8'($urandom)), 1'b0);
            si++;
         end else if (ei < n_ends) begin
            push_word(mrfc_pkg::END_WORD, 1'b0);
            ei++;
         end
      end

      if (flavor == FR_LAST_NOT_END)
         last_word = {mrfc_pkg::OP_END, 12'($urandom_range(1, 4095))};
      else last_word = mrfc_pkg::END_WORD;
      push_word(last_word, 1'b1);
   endtask

   // stimulus and end of run
   initial begin
      logic [15:0]      crc;
      int unsigned      r;
      bit               long_done;
      frame_flavor_type flavor;
      long_done = 1'b0;

      // final mark on the very first word
      push_word(16'hFFFF, 1'b1);
      // final mark inside the begin stamp
      push_word(16'h0000, 1'b0);
      push_word(16'h8001, 1'b0);
      push_word(16'h7FFE, 1'b1);
      // a single read byte only
      push_word(16'h0000, 1'b0);
      push_word(16'hFFFF, 1'b0);
      push_word(16'h0000, 1'b0);
      push_word(16'hFFFF, 1'b0);
      push_word(read_word(8'hA5), 1'b0);
      push_word(mrfc_pkg::END_WORD, 1'b1);
      // clean frame with extreme byte values
      push_word(16'hFFFF, 1'b0);
      push_word(16'h0000, 1'b0);
      push_word(16'hFFFF, 1'b0);
      push_word(16'h0000, 1'b0);
      crc = crc_step(crc_step(16'hFFFF, 8'h00), 8'hFF);
      push_word(read_word(8'h00), 1'b0);
      push_word(read_word(8'hFF), 1'b0);
      push_word(read_word(crc[7:0]), 1'b0);
      push_word(read_word(crc[15:8]), 1'b0);
      for (int i = 0; i < 8; i++) push_word(stamp_word(i[0] ? 8'hFF : 8'h00), 1'b0);
      push_word(mrfc_pkg::END_WORD, 1'b1);

      while (items_queued < RANDOM_WORDS) begin
         if (!long_done && items_queued > RANDOM_WORDS / 2) begin
            // one frame that runs past the word cap
            queue_frame(FR_LONG);
            long_done = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 55) flavor = FR_GOOD;
         else if (r < 62) flavor = FR_BAD_CRC;
         else if (r < 68) flavor = FR_EXTRA_STAMP;
         else if (r < 74) flavor = FR_FEW_STAMP;
         else if (r < 80) flavor = FR_MULTI_END;
         else if (r < 86) flavor = FR_LAST_NOT_END;
         else if (r < 91) flavor = FR_FEW_BYTES;
         else if (r < 95) flavor = FR_SHORT;
         else flavor = FR_NOISE;
         queue_frame(flavor);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (words_to_send.size() != 0 || req_valid) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            model_frame_word(req_data);
            words_taken++;
            if ($urandom_range(0, 149) == 0) calm = !calm;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0 || words_to_send.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap > 0) send_gap--;
            end else begin
               req_data  <= words_to_send.pop_front();
               req_valid <= 1'b1;
               send_gap   = pick_gap();
            end
         end
      end
   end

   // receiver stall, with one long hold-off so the result queue fills up
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!pressure_done && words_taken >= HOLD_AFTER) begin
         pressure_done = 1'b1;
         hold_left     = HOLD_CYCLES - 1;
         rsp_stall    <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      mrfc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("item on result channel with nothing expected");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("kind", 64'(want.kind), 64'(rsp_data.kind));
            compare_field("data_byte", 64'(want.data_byte), 64'(rsp_data.data_byte));
            compare_field("status", 64'(want.status), 64'(rsp_data.status));
            compare_field("begin_stamp", want.begin_stamp, rsp_data.begin_stamp);
            compare_field("end_stamp", want.end_stamp, rsp_data.end_stamp);
            compare_field("payload_count", 64'(want.payload_count),
                          64'(rsp_data.payload_count));
            compare_field("crc_received", 64'(want.crc_received),
                          64'(rsp_data.crc_received));
            compare_field("crc_computed", 64'(want.crc_computed),
                          64'(rsp_data.crc_computed));
            compare_field("last", 64'(want.last), 64'(rsp_data.last));
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
